>>> rtl/core/fuzzy_membership_threshold_filter_unit_macros.svh
// Assertion macros for the possibility filter.
`ifndef FUZZY_MEMBERSHIP_THRESHOLD_FILTER_UNIT_MACROS_SVH
`define FUZZY_MEMBERSHIP_THRESHOLD_FILTER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FMTF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("fmtf assertion failed");
`define FMTF_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("fmtf assertion failed");
`else
`define FMTF_ASSERT(lbl, clk, rst, prop)
`define FMTF_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> rtl/core/fmtf_pkg.sv
package fmtf_pkg;
   localparam int FRAC_BITS_DEF = 16;
   localparam int REQ_W  = 128;
   localparam int VAL_W  = 32;
   localparam int SPR_W  = 31;
   localparam int THR_W  = 17;
   localparam int OP_W   = 3;
   localparam int IDX_W  = 3;
   localparam int PT_W   = 35;   // edge points
   localparam int RW     = 38;   // numerator, divisor, remainder
   localparam int CW     = 32;   // threshold compare width

   typedef enum logic [IDX_W-1:0] {
      CSR_REF_PEAK   = 3'd0,
      CSR_REF_LEFT   = 3'd1,
      CSR_REF_CORE   = 3'd2,
      CSR_REF_RIGHT  = 3'd3,
      CSR_CMP_OP     = 3'd4,
      CSR_THRESHOLD  = 3'd5,
      CSR_NEGATE     = 3'd6
   } csr_idx_type;

   typedef enum logic [OP_W-1:0] {
      CMP_EQ     = 3'd0,
      CMP_NE     = 3'd1,
      CMP_LT     = 3'd2,
      CMP_LE     = 3'd3,
      CMP_GT     = 3'd4,
      CMP_GE     = 3'd5,
      CMP_ALWAYS = 3'd6
   } cmp_op_type;

   typedef struct packed {
      logic [RW-1:0] num;
      logic [RW-1:0] den;
   } div_job_type;

   // foot/shoulder pair crossing set-up; a miss gives 0/1
   function automatic div_job_type cross_setup(input logic signed [PT_W-1:0] f1,
                                               input logic signed [PT_W-1:0] s1,
                                               input logic signed [PT_W-1:0] f2,
                                               input logic signed [PT_W-1:0] s2);
      div_job_type j;
      logic signed [RW-1:0] n;
      logic signed [RW-1:0] d;
      logic hit;
      hit = (f1 < f2 && s1 > s2) || (f2 < f1 && s2 > s1);
      n = RW'(f1) - RW'(f2);
      d = (RW'(s2) - RW'(f2)) - (RW'(s1) - RW'(f1));
      if (hit) begin
         j.num = n[RW-1] ? -n : n;
         j.den = d[RW-1] ? -d : d;
      end else begin
         j.num = '0;
         j.den = RW'(1);
      end
      return j;
   endfunction
endpackage

>>> rtl/core/fmtf_prep.sv
module fmtf_prep
   import fmtf_pkg::*;
(
   input  logic                     clock,
   input  logic                     en,
   input  logic [VAL_W-1:0]         in_peak,
   input  logic [SPR_W-1:0]         in_left,
   input  logic [SPR_W-1:0]         in_core,
   input  logic [SPR_W-1:0]         in_right,
   input  logic [VAL_W-1:0]         ref_peak,
   input  logic [SPR_W-1:0]         ref_left,
   input  logic [SPR_W-1:0]         ref_core,
   input  logic [SPR_W-1:0]         ref_right,
   output logic                     ovl,
   output div_job_type [3:0]        jobs
);
   logic signed [PT_W-1:0] m1_ff, l1_ff, n1_ff, o1_ff;
   logic signed [PT_W-1:0] m2_ff, l2_ff, n2_ff, o2_ff;
   logic signed [PT_W-1:0] m1_in, l1_in, n1_in, o1_in;
   logic signed [PT_W-1:0] m2_in, l2_in, n2_in, o2_in;
   logic                   ovl_ff, ovl_in;
   div_job_type [3:0]      jobs_ff, jobs_in;

   // stage A: edge points
   always_comb begin
      m1_in = {{(PT_W-VAL_W){ref_peak[VAL_W-1]}}, ref_peak};
      l1_in = m1_in - PT_W'(ref_left);
      n1_in = m1_in + PT_W'(ref_core);
      o1_in = n1_in + PT_W'(ref_right);
      m2_in = {{(PT_W-VAL_W){in_peak[VAL_W-1]}}, in_peak};
      l2_in = m2_in - PT_W'(in_left);
      n2_in = m2_in + PT_W'(in_core);
      o2_in = n2_in + PT_W'(in_right);
   end

   // stage B: core overlap and divider jobs
   always_comb begin
      ovl_in = (m1_ff <= m2_ff && n1_ff >= m2_ff) || (m2_ff <= m1_ff && n2_ff >= m1_ff);
      jobs_in[0] = cross_setup(l1_ff, m1_ff, l2_ff, m2_ff);
      jobs_in[1] = cross_setup(l1_ff, m1_ff, o2_ff, n2_ff);
      jobs_in[2] = cross_setup(o1_ff, n1_ff, l2_ff, m2_ff);
      jobs_in[3] = cross_setup(o1_ff, n1_ff, o2_ff, n2_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff <= m1_in; l1_ff <= l1_in; n1_ff <= n1_in; o1_ff <= o1_in;
         m2_ff <= m2_in; l2_ff <= l2_in; n2_ff <= n2_in; o2_ff <= o2_in;
         ovl_ff  <= ovl_in;
         jobs_ff <= jobs_in;
      end
   end

   assign ovl  = ovl_ff;
   assign jobs = jobs_ff;
endmodule

>>> rtl/core/fmtf_divider.sv
// Restoring divider lane, one quotient bit per stage; num < den on entry.
module fmtf_divider
   import fmtf_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 en,
   input  div_job_type          job,
   output logic [FRAC_BITS-1:0] quot
);
   logic [RW-1:0]        r_ff [FRAC_BITS];
   logic [RW-1:0]        d_ff [FRAC_BITS];
   logic [FRAC_BITS-1:0] q_ff [FRAC_BITS];
   logic [RW-1:0]        r_in [FRAC_BITS];
   logic [FRAC_BITS-1:0] q_in [FRAC_BITS];
   // operands seen by each stage
   logic [RW-1:0]        r_src [FRAC_BITS];
   logic [RW-1:0]        d_src [FRAC_BITS];
   logic [FRAC_BITS-1:0] q_src [FRAC_BITS];

   always_comb begin
      logic [RW-1:0] r2;
      r_src[0] = job.num;
      d_src[0] = job.den;
      q_src[0] = '0;
      for (int k = 1; k < FRAC_BITS; k++) begin
         r_src[k] = r_ff[k-1];
         d_src[k] = d_ff[k-1];
         q_src[k] = q_ff[k-1];
      end
      for (int k = 0; k < FRAC_BITS; k++) begin
         r2 = {r_src[k][RW-2:0], 1'b0};
         if (r2 >= d_src[k]) begin
            r_in[k] = r2 - d_src[k];
            q_in[k] = {q_src[k][FRAC_BITS-2:0], 1'b1};
         end else begin
            r_in[k] = r2;
            q_in[k] = {q_src[k][FRAC_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < FRAC_BITS; k++) begin
            r_ff[k] <= r_in[k];
            d_ff[k] <= d_src[k];
            q_ff[k] <= q_in[k];
         end
      end
   end

   assign quot = q_ff[FRAC_BITS-1];
endmodule

>>> rtl/core/fuzzy_membership_threshold_filter_unit.sv
// Channel | dir | tdata fields (low bit up)
// req     | in  | in_peak_start[31:0] in_left_spread[62:32] in_core_width[93:63]
//         |     | in_right_spread[124:94], zero pad to 128
// rsp     | out | membership_degree[FRAC_BITS:0] match[FRAC_BITS+1], zero pad
// csr     | in  | csr_we, csr_addr (register index), csr_wdata (32 bit)
//
// Registered through the prep stages, the divider stages and the output register; one beat a cycle unless rsp is held.
// Depth is set by the four restoring divider lanes, one quotient bit a stage.
// Reset (synchronous) clears valid bits and loads register defaults.
// The whole pipe holds while a result waits; nothing is dropped or repeated.
module fuzzy_membership_threshold_filter_unit
   import fmtf_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [REQ_W-1:0]     req_tdata,  // peak, left, core, right spread
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [((FRAC_BITS+2+7)/8)*8-1:0] rsp_tdata, // degree, match
   input  logic                 csr_we,
   input  logic [IDX_W-1:0]     csr_addr,
   input  logic [VAL_W-1:0]     csr_wdata
);
   `include "fuzzy_membership_threshold_filter_unit_macros.svh"

   localparam int DW   = FRAC_BITS + 1;
   localparam int RSPW = ((FRAC_BITS + 2 + 7) / 8) * 8;

   // configuration registers
   logic [VAL_W-1:0] ref_peak_ff;
   logic [SPR_W-1:0] ref_left_ff, ref_core_ff, ref_right_ff;
   logic [OP_W-1:0]  cmp_op_ff;
   logic [THR_W-1:0] thr_ff;
   logic             neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_peak_ff  <= '0;
         ref_left_ff  <= '0;
         ref_core_ff  <= '0;
         ref_right_ff <= '0;
         cmp_op_ff    <= CMP_ALWAYS;
         thr_ff       <= '0;
         neg_ff       <= 1'b0;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_addr))
            CSR_REF_PEAK:  ref_peak_ff  <= csr_wdata;
            CSR_REF_LEFT:  ref_left_ff  <= csr_wdata[SPR_W-1:0];
            CSR_REF_CORE:  ref_core_ff  <= csr_wdata[SPR_W-1:0];
            CSR_REF_RIGHT: ref_right_ff <= csr_wdata[SPR_W-1:0];
            CSR_CMP_OP:    cmp_op_ff    <= csr_wdata[OP_W-1:0];
            CSR_THRESHOLD: thr_ff       <= csr_wdata[THR_W-1:0];
            CSR_NEGATE:    neg_ff       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // global advance: output slot empty or being drained
   logic en;
   logic rsp_valid_ff;
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // valid bits: two prep stages, FRAC_BITS divider stages
   logic                 va_ff, vb_ff;
   logic [FRAC_BITS-1:0] vd_ff;
   logic [FRAC_BITS-1:0] ovl_ff;

   logic              ovl;
   div_job_type [3:0] jobs;
   logic [FRAC_BITS-1:0] quot [4];

   fmtf_prep u_prep (
      .clock    (clock),
      .en       (en),
      .in_peak  (req_tdata[31:0]),
      .in_left  (req_tdata[62:32]),
      .in_core  (req_tdata[93:63]),
      .in_right (req_tdata[124:94]),
      .ref_peak (ref_peak_ff),
      .ref_left (ref_left_ff),
      .ref_core (ref_core_ff),
      .ref_right(ref_right_ff),
      .ovl      (ovl),
      .jobs     (jobs)
   );

   for (genvar g = 0; g < 4; g++) begin : g_lane
      fmtf_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
         .clock(clock),
         .en   (en),
         .job  (jobs[g]),
         .quot (quot[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vd_ff <= '0;
      end else if (en) begin
         va_ff <= req_tvalid;
         vb_ff <= va_ff;
         vd_ff <= {vd_ff[FRAC_BITS-2:0], vb_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ovl_ff <= {ovl_ff[FRAC_BITS-2:0], ovl};
      end
   end

   // decision: largest crossing, overlap forces one, then threshold test
   logic [FRAC_BITS-1:0] mx01, mx23, mx;
   logic [DW-1:0]        deg_in;
   logic [CW-1:0]        deg_w, thr_w;
   logic                 hit, match_in;

   always_comb begin
      mx01   = (quot[0] > quot[1]) ? quot[0] : quot[1];
      mx23   = (quot[2] > quot[3]) ? quot[2] : quot[3];
      mx     = (mx01 > mx23) ? mx01 : mx23;
      deg_in = ovl_ff[FRAC_BITS-1] ? (DW'(1) << FRAC_BITS) : DW'(mx);
      deg_w  = CW'(deg_in);
      thr_w  = CW'(thr_ff);
      case (cmp_op_ff)
         CMP_EQ:  hit = deg_w == thr_w;
         CMP_NE:  hit = deg_w != thr_w;
         CMP_LT:  hit = deg_w <  thr_w;
         CMP_LE:  hit = deg_w <= thr_w;
         CMP_GT:  hit = deg_w >  thr_w;
         CMP_GE:  hit = deg_w >= thr_w;
         default: hit = 1'b1;   // always, and the spare code
      endcase
      match_in = hit ^ neg_ff;
   end

   logic [DW-1:0] deg_ff;
   logic          match_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vd_ff[FRAC_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         deg_ff   <= deg_in;
         match_ff <= match_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSPW'({match_ff, deg_ff});

   `FMTF_ASSERT(a_deg_max, clock, reset, rsp_tvalid |-> (deg_ff <= (DW'(1) << FRAC_BITS)))
   `FMTF_ASSERT(a_always, clock, reset, (rsp_tvalid && cmp_op_ff == CMP_ALWAYS && !neg_ff) |-> match_ff)
   `FMTF_ASSERT(a_ready, clock, reset, req_tready == (!rsp_tvalid || rsp_tready))
   `FMTF_ASSERT_ALWAYS(a_rst, clock, $past(reset) |-> !rsp_tvalid)
endmodule
